// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ===== hw/rtl/rvx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_pkg
// Operation, function and status codes plus the class bits that travel from
// the front end to the execute back end.
// ----------------------------------------------------------------------------
package rvx_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned RegFieldW = 8;

  typedef enum logic [3:0] {
    OP_IMM    = 4'd0,
    OP_ALU_R  = 4'd1,
    OP_ALU_I  = 4'd2,
    OP_GOTO   = 4'd3,
    OP_IFNZ   = 4'd4,
    OP_BR_R   = 4'd5,
    OP_BR_I   = 4'd6,
    OP_UNARY  = 4'd7,
    OP_CALL   = 4'd8,
    OP_RET    = 4'd9,
    OP_END    = 4'd10
  } op_e;

  typedef enum logic [4:0] {
    FN_ADD  = 5'd0,
    FN_SUB  = 5'd1,
    FN_MUL  = 5'd2,
    FN_DIV  = 5'd3,
    FN_MOD  = 5'd4,
    FN_EQ   = 5'd5,
    FN_NE   = 5'd6,
    FN_LT   = 5'd7,
    FN_LE   = 5'd8,
    FN_GT   = 5'd9,
    FN_GE   = 5'd10,
    FN_LAND = 5'd11,
    FN_LOR  = 5'd12,
    FN_AND  = 5'd13,
    FN_OR   = 5'd14,
    FN_XOR  = 5'd15,
    FN_SHL  = 5'd16,
    FN_SHR  = 5'd17
  } alu_fn_e;

  typedef enum logic [4:0] {
    UN_NEG = 5'd0,
    UN_NOT = 5'd1,
    UN_CMP = 5'd2,
    UN_ABS = 5'd3,
    UN_MOV = 5'd4
  } un_fn_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_OVF   = 3'd1,
    ST_UNF   = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_RANGE = 3'd4
  } status_e;

  // Classification done at accept time.
  typedef struct packed {
    logic alu;     // binary op writing a register
    logic branch;  // binary op steering the pc
    logic reg_b;   // right operand comes from the register file
    logic mul;     // needs the multi-cycle multiplier
    logic divmod;  // needs the divider
  } cls_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rvx_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rvx_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rvx_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_front
// Accepts instruction transactions, classifies them and holds them in a
// two-entry queue for the execute back end.
// ----------------------------------------------------------------------------
module rvx_front #(
  parameter int unsigned PcW = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire logic [3:0]          operation_i,
  input  wire logic [4:0]          function_code_i,
  input  wire logic [7:0]          dest_reg_i,
  input  wire logic [7:0]          lhs_reg_i,
  input  wire logic [7:0]          rhs_reg_i,
  input  wire logic [63:0]         immediate_i,
  input  wire logic [PcW-1:0]      target_i,
  input  wire logic [PcW-1:0]      next_address_i,
  output logic                     hd_valid_o,
  input  wire logic                hd_pop_i,
  output rvx_pkg::op_e             hd_op_o,
  output logic [4:0]               hd_fn_o,
  output rvx_pkg::cls_t            hd_cls_o,
  output logic [7:0]               hd_dest_o,
  output logic [7:0]               hd_lhs_o,
  output logic [7:0]               hd_rhs_o,
  output logic [63:0]              hd_imm_o,
  output logic [PcW-1:0]           hd_tgt_o,
  output logic [PcW-1:0]           hd_nxt_o
);
  import rvx_pkg::*;

  localparam int unsigned QDepth = 2;

  op_e           op_mem_q  [QDepth];
  logic [4:0]    fn_mem_q  [QDepth];
  cls_t          cls_mem_q [QDepth];
  logic [7:0]    rd_mem_q  [QDepth];
  logic [7:0]    rl_mem_q  [QDepth];
  logic [7:0]    rr_mem_q  [QDepth];
  logic [63:0]   imm_mem_q [QDepth];
  logic [PcW-1:0] tgt_mem_q [QDepth];
  logic [PcW-1:0] nxt_mem_q [QDepth];

  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  op_e        in_op;
  alu_fn_e    in_fn;
  cls_t       in_cls;

  assign full_o     = (cnt_q == 2'(QDepth));
  assign hd_valid_o = (cnt_q != 2'd0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = hd_pop_i && hd_valid_o;

  always_comb begin
    in_op = op_e'(operation_i);
    in_fn = alu_fn_e'(function_code_i);
    in_cls.alu    = (in_op == OP_ALU_R) || (in_op == OP_ALU_I);
    in_cls.branch = (in_op == OP_BR_R) || (in_op == OP_BR_I);
    in_cls.reg_b  = (in_op == OP_ALU_R) || (in_op == OP_BR_R);
    in_cls.mul    = (in_cls.alu || in_cls.branch) && (in_fn == FN_MUL);
    in_cls.divmod = (in_cls.alu || in_cls.branch) &&
                    ((in_fn == FN_DIV) || (in_fn == FN_MOD));
  end

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      op_mem_q[wr_ptr_q]  <= in_op;
      fn_mem_q[wr_ptr_q]  <= function_code_i;
      cls_mem_q[wr_ptr_q] <= in_cls;
      rd_mem_q[wr_ptr_q]  <= dest_reg_i;
      rl_mem_q[wr_ptr_q]  <= lhs_reg_i;
      rr_mem_q[wr_ptr_q]  <= rhs_reg_i;
      imm_mem_q[wr_ptr_q] <= immediate_i;
      tgt_mem_q[wr_ptr_q] <= target_i;
      nxt_mem_q[wr_ptr_q] <= next_address_i;
    end
  end

  assign hd_op_o   = op_mem_q[rd_ptr_q];
  assign hd_fn_o   = fn_mem_q[rd_ptr_q];
  assign hd_cls_o  = cls_mem_q[rd_ptr_q];
  assign hd_dest_o = rd_mem_q[rd_ptr_q];
  assign hd_lhs_o  = rl_mem_q[rd_ptr_q];
  assign hd_rhs_o  = rr_mem_q[rd_ptr_q];
  assign hd_imm_o  = imm_mem_q[rd_ptr_q];
  assign hd_tgt_o  = tgt_mem_q[rd_ptr_q];
  assign hd_nxt_o  = nxt_mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== hw/rtl/rvx_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_div
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rvx_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [63:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quotient_o,
  output logic [63:0]      remainder_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, quo_q, dvs_q;
  logic [64:0] rem_sh, diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[63]};
    diff   = rem_sh - {1'b0, dvs_q};
    ge     = (rem_sh >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd63;
    end else if (busy_q) begin
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 64'd0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[63:0] : rem_sh[63:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rvx_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_back
// Execute back end: register file, frame stack, ALU, shared multiplier and
// divider, and the architectural state (window base, frame count, halt).
// ----------------------------------------------------------------------------
module rvx_back #(
  parameter int unsigned REGISTER_COUNT = 1024,
  parameter int unsigned FRAME_DEPTH    = 256,
  parameter int unsigned PcW            = 12
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  output logic                                   clearing_o,
  input  wire logic                              hd_valid_i,
  output logic                                   hd_pop_o,
  input  rvx_pkg::op_e                           hd_op_i,
  input  wire logic [4:0]                        hd_fn_i,
  input  rvx_pkg::cls_t                          hd_cls_i,
  input  wire logic [7:0]                        hd_dest_i,
  input  wire logic [7:0]                        hd_lhs_i,
  input  wire logic [7:0]                        hd_rhs_i,
  input  wire logic [63:0]                       hd_imm_i,
  input  wire logic [PcW-1:0]                    hd_tgt_i,
  input  wire logic [PcW-1:0]                    hd_nxt_i,
  input  wire logic                              out_room_i,
  output logic                                   res_push_o,
  output logic [PcW-1:0]                         res_pc_o,
  output logic                                   res_we_o,
  output logic [$clog2(REGISTER_COUNT)-1:0]      res_wi_o,
  output logic [63:0]                            res_wv_o,
  output logic                                   res_halt_o,
  output rvx_pkg::status_e                       res_st_o
);
  import rvx_pkg::*;

  localparam int unsigned RegW = $clog2(REGISTER_COUNT);
  localparam int unsigned FcW  = $clog2(FRAME_DEPTH);
  localparam int unsigned FrW  = RegW + PcW + RegFieldW;
  localparam logic [RegW:0]   RegCnt  = (RegW + 1)'(REGISTER_COUNT);
  localparam logic [RegW-1:0] LastReg = RegW'(REGISTER_COUNT - 1);
  localparam logic [FcW-1:0]  FullCnt = FcW'(FRAME_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_MUL, S_DIV, S_DONE
  } state_e;

  state_e         state_q, state_d;
  logic [RegW-1:0] clr_q, clr_d;
  logic [RegW-1:0] base_q, base_d;
  logic [FcW-1:0] fcnt_q, fcnt_d;
  logic           halt_q, halt_d;
  logic [1:0]     step_q, step_d;
  logic [63:0]    res_q, res_d;

  op_e            op_q;
  logic [4:0]     fn_q;
  cls_t           cls_q;
  logic [7:0]     rd_q, rl_q, rr_q;
  logic [63:0]    imm_q;
  logic [PcW-1:0] tgt_q, nxt_q;

  logic            rd_en;
  logic [RegW-1:0] ra_addr, rb_addr;
  logic [RegW:0]   ra_sum, rb_sum;
  logic            rf_we;
  logic [RegW-1:0] rf_waddr;
  logic [63:0]     rf_wdata;
  logic [63:0]     a, b, rb_data;
  logic            fr_we;
  logic [FrW-1:0]  fr_rdata;
  logic [RegW-1:0] fr_base;
  logic [PcW-1:0]  fr_ret;
  logic [7:0]      fr_out;

  logic [RegW:0]   sum_l, sum_r, sum_d, sum_o;
  logic            ok_l, ok_r, ok_d, ok_o, ok_alu, ok_br, b_zero, dz, is_long, fin_go;
  logic [63:0]     alu_res, un_res, res_fin;
  logic            alu_known, un_known;

  logic [31:0]     mul_x, mul_y;
  logic [63:0]     prod;
  logic            div_start, div_done;
  logic [63:0]     div_q, div_r, div_val;
  logic            div_neg;

  // read ports are driven while the head transaction is taken
  assign rd_en    = (state_q == S_IDLE) && hd_valid_i && out_room_i;
  assign hd_pop_o = rd_en;
  assign ra_sum   = {1'b0, base_q} + (RegW + 1)'(hd_lhs_i);
  assign rb_sum   = {1'b0, base_q} + (RegW + 1)'(hd_rhs_i);
  assign ra_addr  = ra_sum[RegW-1:0];
  assign rb_addr  = rb_sum[RegW-1:0];

  // two copies of the register file give two read ports
  rvx_ram #(.Width(DataW), .Depth(REGISTER_COUNT)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (rd_en),
    .raddr_i (ra_addr),
    .rdata_o (a)
  );

  rvx_ram #(.Width(DataW), .Depth(REGISTER_COUNT)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (rd_en),
    .raddr_i (rb_addr),
    .rdata_o (rb_data)
  );

  rvx_ram #(.Width(FrW), .Depth(FRAME_DEPTH)) u_frames (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fcnt_q),
    .wdata_i ({base_q, nxt_q, rd_q}),
    .re_i    (rd_en),
    .raddr_i (fcnt_q - FcW'(1)),
    .rdata_o (fr_rdata)
  );

  rvx_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (a[63] ? (64'd0 - a) : a),
    .divisor_i   (b[63] ? (64'd0 - b) : b),
    .done_o      (div_done),
    .quotient_o  (div_q),
    .remainder_o (div_r)
  );

  assign {fr_base, fr_ret, fr_out} = fr_rdata;
  assign b = cls_q.reg_b ? rb_data : imm_q;

  always_comb begin
    sum_l  = {1'b0, base_q} + (RegW + 1)'(rl_q);
    sum_r  = {1'b0, base_q} + (RegW + 1)'(rr_q);
    sum_d  = {1'b0, base_q} + (RegW + 1)'(rd_q);
    sum_o  = {1'b0, fr_base} + (RegW + 1)'(fr_out);
    ok_l   = sum_l < RegCnt;
    ok_r   = sum_r < RegCnt;
    ok_d   = sum_d < RegCnt;
    ok_o   = sum_o < RegCnt;
    ok_br  = ok_l && (!cls_q.reg_b || ok_r);
    ok_alu = ok_br && ok_d;
    b_zero = (b == 64'd0);
    dz     = cls_q.divmod && b_zero;
    is_long = !halt_q && (cls_q.alu ? ok_alu : (cls_q.branch && ok_br)) &&
              (cls_q.mul || (cls_q.divmod && !b_zero));
  end

  // combinational binary ALU
  always_comb begin
    alu_res   = 64'd0;
    alu_known = 1'b1;
    case (alu_fn_e'(fn_q))
      FN_ADD:  alu_res = a + b;
      FN_SUB:  alu_res = a - b;
      FN_MUL, FN_DIV, FN_MOD: alu_res = 64'd0;  // produced by the long units
      FN_EQ:   alu_res = {63'd0, a == b};
      FN_NE:   alu_res = {63'd0, a != b};
      FN_LT:   alu_res = {63'd0, $signed(a) < $signed(b)};
      FN_LE:   alu_res = {63'd0, $signed(a) <= $signed(b)};
      FN_GT:   alu_res = {63'd0, $signed(a) > $signed(b)};
      FN_GE:   alu_res = {63'd0, $signed(a) >= $signed(b)};
      FN_LAND: alu_res = {63'd0, (a != 64'd0) && (b != 64'd0)};
      FN_LOR:  alu_res = {63'd0, (a != 64'd0) || (b != 64'd0)};
      FN_AND:  alu_res = a & b;
      FN_OR:   alu_res = a | b;
      FN_XOR:  alu_res = a ^ b;
      FN_SHL:  alu_res = a << b[5:0];
      FN_SHR:  alu_res = 64'($signed(a) >>> b[5:0]);
      default: alu_known = 1'b0;
    endcase
  end

  always_comb begin
    un_res   = 64'd0;
    un_known = 1'b1;
    case (un_fn_e'(fn_q))
      UN_NEG:  un_res = 64'd0 - a;
      UN_NOT:  un_res = {63'd0, a == 64'd0};
      UN_CMP:  un_res = ~a;
      UN_ABS:  un_res = a[63] ? (64'd0 - a) : a;
      UN_MOV:  un_res = a;
      default: un_known = 1'b0;
    endcase
  end

  // one 32x32 multiplier, three partial products for the low 64 bits
  always_comb begin
    mul_x   = (step_q == 2'd2) ? a[63:32] : a[31:0];
    mul_y   = (step_q == 2'd1) ? b[63:32] : b[31:0];
    prod    = 64'(mul_x) * 64'(mul_y);
    div_neg = (alu_fn_e'(fn_q) == FN_DIV) ? (a[63] ^ b[63]) : a[63];
    div_val = (alu_fn_e'(fn_q) == FN_DIV) ? div_q : div_r;
  end

  assign fin_go    = ((state_q == S_EXEC) && !is_long) || (state_q == S_DONE);
  assign div_start = (state_q == S_EXEC) && is_long && cls_q.divmod;
  assign res_fin   = (state_q == S_DONE) ? res_q : alu_res;
  assign clearing_o = (state_q == S_CLEAR);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    base_d     = base_q;
    fcnt_d     = fcnt_q;
    halt_d     = halt_q;
    step_d     = step_q;
    res_d      = res_q;
    fr_we      = 1'b0;
    res_pc_o   = nxt_q;
    res_we_o   = 1'b0;
    res_wi_o   = '0;
    res_wv_o   = 64'd0;
    res_st_o   = ST_OK;

    if (!halt_q) begin
      unique case (op_q)
        OP_IMM: begin
          if (!ok_d) begin
            res_st_o = ST_RANGE;
          end else begin
            res_we_o = 1'b1;
            res_wi_o = sum_d[RegW-1:0];
            res_wv_o = imm_q;
          end
        end
        OP_ALU_R, OP_ALU_I: begin
          if (!ok_alu) begin
            res_st_o = ST_RANGE;
          end else if (dz) begin
            res_st_o = ST_DIVZ;
          end else if (alu_known) begin
            res_we_o = 1'b1;
            res_wi_o = sum_d[RegW-1:0];
            res_wv_o = res_fin;
          end
        end
        OP_GOTO: res_pc_o = tgt_q;
        OP_IFNZ: begin
          if (!ok_l) begin
            res_st_o = ST_RANGE;
          end else begin
            res_pc_o = (a != 64'd0) ? nxt_q : tgt_q;
          end
        end
        OP_BR_R, OP_BR_I: begin
          // the branch is taken to target when the test comes out false
          if (!ok_br) begin
            res_st_o = ST_RANGE;
          end else if (dz) begin
            res_st_o = ST_DIVZ;
          end else if (alu_known) begin
            res_pc_o = (res_fin != 64'd0) ? nxt_q : tgt_q;
          end
        end
        OP_UNARY: begin
          if (!(ok_l && ok_d)) begin
            res_st_o = ST_RANGE;
          end else if (un_known) begin
            res_we_o = 1'b1;
            res_wi_o = sum_d[RegW-1:0];
            res_wv_o = un_res;
          end
        end
        OP_CALL: begin
          if (fcnt_q >= FullCnt) begin
            res_st_o = ST_OVF;
          end else if (!(ok_d && ok_l)) begin
            res_st_o = ST_RANGE;
          end else begin
            fr_we    = fin_go;
            res_pc_o = tgt_q;
            if (fin_go) begin
              fcnt_d = fcnt_q + FcW'(1);
              base_d = sum_l[RegW-1:0];
            end
          end
        end
        OP_RET: begin
          if (fcnt_q == '0) begin
            res_st_o = ST_UNF;
          end else if (!(ok_l && ok_o)) begin
            res_st_o = ST_RANGE;
          end else begin
            res_we_o = 1'b1;
            res_wi_o = sum_o[RegW-1:0];
            res_wv_o = a;
            res_pc_o = fr_ret;
            if (fin_go) begin
              fcnt_d = fcnt_q - FcW'(1);
              base_d = fr_base;
            end
          end
        end
        OP_END: begin
          if (fin_go) begin
            halt_d = 1'b1;
          end
        end
        default: ;
      endcase
    end

    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + RegW'(1);
        if (clr_q == LastReg) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (rd_en) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!is_long) begin
          state_d = S_IDLE;
        end else if (cls_q.mul) begin
          step_d  = 2'd0;
          state_d = S_MUL;
        end else begin
          state_d = S_DIV;
        end
      end
      S_MUL: begin
        res_d  = (step_q == 2'd0) ? prod : (res_q + {prod[31:0], 32'd0});
        step_d = step_q + 2'd1;
        if (step_q == 2'd2) begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = div_neg ? (64'd0 - div_val) : div_val;
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase

    res_push_o = fin_go;
    res_halt_o = halt_d;
    if (state_q == S_CLEAR) begin
      rf_we    = 1'b1;
      rf_waddr = clr_q;
      rf_wdata = 64'd0;
    end else begin
      rf_we    = fin_go && res_we_o;
      rf_waddr = res_wi_o;
      rf_wdata = res_wv_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      base_q  <= '0;
      fcnt_q  <= '0;
      halt_q  <= 1'b0;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      base_q  <= base_d;
      fcnt_q  <= fcnt_d;
      halt_q  <= halt_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (rd_en) begin
      op_q  <= hd_op_i;
      fn_q  <= hd_fn_i;
      cls_q <= hd_cls_i;
      rd_q  <= hd_dest_i;
      rl_q  <= hd_lhs_i;
      rr_q  <= hd_rhs_i;
      imm_q <= hd_imm_i;
      tgt_q <= hd_tgt_i;
      nxt_q <= hd_nxt_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/register_vm_execute_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// register_vm_execute_unit
// Executes decoded register-VM instructions, one result per instruction.
// ----------------------------------------------------------------------------
// Usage:
//   Instructions enter through a queue-style port: a transaction is taken on
//   a clock edge with push high and full low. Results leave through a
//   second queue-style port: the oldest result sits on the result ports while
//   empty is low and is removed on an edge with pop high.
//   After reset the register file is zeroed by a sweep over all REGISTER_COUNT
//   entries with full held high; window base, frame count and halt reset to 0.
//   A result reaches the outputs through the execute registers and the result
//   queue. The back end reads the register file, then executes and writes back,
//   and takes no new instruction until it is back in idle.
//   Multiply forms three 32x32 partial products on one multiplier; divide and
//   modulo use a radix-2 divider.
//   A two-entry queue sits on each side of the execute stage. When pop is
//   held low the result queue fills, the back end stops taking instructions,
//   and full rises once the input queue is full; nothing is lost.
// ----------------------------------------------------------------------------
module register_vm_execute_unit #(
  parameter int unsigned REGISTER_COUNT = 1024,
  parameter int unsigned FRAME_DEPTH    = 256,
  parameter int unsigned CODE_SIZE      = 4096
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [3:0]                          operation_i,
  input  wire logic [4:0]                          function_code_i,
  input  wire logic [7:0]                          dest_reg_i,
  input  wire logic [7:0]                          lhs_reg_i,
  input  wire logic [7:0]                          rhs_reg_i,
  input  wire logic signed [63:0]                  immediate_i,
  input  wire logic [$clog2(CODE_SIZE)-1:0]        target_i,
  input  wire logic [$clog2(CODE_SIZE)-1:0]        next_address_i,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [$clog2(CODE_SIZE)-1:0]             next_pc_o,
  output logic                                     write_enable_o,
  output logic [$clog2(REGISTER_COUNT)-1:0]        write_index_o,
  output logic signed [63:0]                       write_value_o,
  output logic                                     halted_o,
  output logic [2:0]                               status_o
);
  import rvx_pkg::*;

`include "assert_macros.svh"

  localparam int unsigned PcW  = $clog2(CODE_SIZE);
  localparam int unsigned RegW = $clog2(REGISTER_COUNT);
  localparam int unsigned ODepth = 2;

  logic           front_full, clearing;
  logic           hd_valid, hd_pop;
  op_e            hd_op;
  logic [4:0]     hd_fn;
  cls_t           hd_cls;
  logic [7:0]     hd_dest, hd_lhs, hd_rhs;
  logic [63:0]    hd_imm;
  logic [PcW-1:0] hd_tgt, hd_nxt;

  logic            res_push, res_we, res_halt;
  logic [PcW-1:0]  res_pc;
  logic [RegW-1:0] res_wi;
  logic [63:0]     res_wv;
  status_e         res_st;

  logic [PcW-1:0]  o_pc_q   [ODepth];
  logic            o_we_q   [ODepth];
  logic [RegW-1:0] o_wi_q   [ODepth];
  logic [63:0]     o_wv_q   [ODepth];
  logic            o_halt_q [ODepth];
  status_e         o_st_q   [ODepth];
  logic            o_wr_q, o_rd_q;
  logic [1:0]      out_cnt_q, out_cnt_d;
  logic            out_pop;

  assign full = front_full || clearing;

  rvx_front #(.PcW(PcW)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push && !clearing),
    .full_o          (front_full),
    .operation_i     (operation_i),
    .function_code_i (function_code_i),
    .dest_reg_i      (dest_reg_i),
    .lhs_reg_i       (lhs_reg_i),
    .rhs_reg_i       (rhs_reg_i),
    .immediate_i     (immediate_i),
    .target_i        (target_i),
    .next_address_i  (next_address_i),
    .hd_valid_o      (hd_valid),
    .hd_pop_i        (hd_pop),
    .hd_op_o         (hd_op),
    .hd_fn_o         (hd_fn),
    .hd_cls_o        (hd_cls),
    .hd_dest_o       (hd_dest),
    .hd_lhs_o        (hd_lhs),
    .hd_rhs_o        (hd_rhs),
    .hd_imm_o        (hd_imm),
    .hd_tgt_o        (hd_tgt),
    .hd_nxt_o        (hd_nxt)
  );

  rvx_back #(
    .REGISTER_COUNT (REGISTER_COUNT),
    .FRAME_DEPTH    (FRAME_DEPTH),
    .PcW            (PcW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clearing_o (clearing),
    .hd_valid_i (hd_valid),
    .hd_pop_o   (hd_pop),
    .hd_op_i    (hd_op),
    .hd_fn_i    (hd_fn),
    .hd_cls_i   (hd_cls),
    .hd_dest_i  (hd_dest),
    .hd_lhs_i   (hd_lhs),
    .hd_rhs_i   (hd_rhs),
    .hd_imm_i   (hd_imm),
    .hd_tgt_i   (hd_tgt),
    .hd_nxt_i   (hd_nxt),
    .out_room_i (out_cnt_q != 2'(ODepth)),
    .res_push_o (res_push),
    .res_pc_o   (res_pc),
    .res_we_o   (res_we),
    .res_wi_o   (res_wi),
    .res_wv_o   (res_wv),
    .res_halt_o (res_halt),
    .res_st_o   (res_st)
  );

  // result queue
  assign empty   = (out_cnt_q == 2'd0);
  assign out_pop = pop && !empty;
  assign out_cnt_d = out_cnt_q + 2'(res_push) - 2'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_wr_q    <= 1'b0;
      o_rd_q    <= 1'b0;
      out_cnt_q <= 2'd0;
    end else begin
      o_wr_q    <= res_push ? !o_wr_q : o_wr_q;
      o_rd_q    <= out_pop ? !o_rd_q : o_rd_q;
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      o_pc_q[o_wr_q]   <= res_pc;
      o_we_q[o_wr_q]   <= res_we;
      o_wi_q[o_wr_q]   <= res_wi;
      o_wv_q[o_wr_q]   <= res_wv;
      o_halt_q[o_wr_q] <= res_halt;
      o_st_q[o_wr_q]   <= res_st;
    end
  end

  assign next_pc_o      = o_pc_q[o_rd_q];
  assign write_enable_o = o_we_q[o_rd_q];
  assign write_index_o  = o_wi_q[o_rd_q];
  assign write_value_o  = o_wv_q[o_rd_q];
  assign halted_o       = o_halt_q[o_rd_q];
  assign status_o       = o_st_q[o_rd_q];

  `ASSERT_NEVER(a_out_overflow, clk_i, rst_ni, res_push && !out_pop && (out_cnt_q == 2'(ODepth)))
  `ASSERT_NEVER(a_err_no_write, clk_i, rst_ni, !empty && (status_o != ST_OK) && write_enable_o)
  `ASSERT_AT(a_pop_drains, clk_i, rst_ni, (out_pop && (out_cnt_q == 2'd1) && !res_push) |=> empty)

endmodule

`default_nettype wire
